// ----- src/tvrp_pkg.sv -----
// shared types and constants for the tagged varint record parser
`default_nettype none
package tvrp_pkg;

  localparam int COLUMN_BITS = 16;
  localparam int ROW_BITS    = 20;
  localparam int LENGTH_BITS = 24;

  localparam int ACC_BITS  = 64;
  // a 7-bit group shifted by up to 63 positions
  localparam int WIDE_BITS = ACC_BITS + 7;

  localparam logic [7:0] ROW_MARKER       = 8'h0a;
  localparam logic [2:0] TAG_TYPE_INT     = 3'h0;
  localparam logic [2:0] TAG_TYPE_FLOAT   = 3'h5;
  localparam logic [2:0] TAG_TYPE_STRING  = 3'h2;
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [3:0] FLOAT_BYTES      = 4'd4;

  // queue between the parser and the result side
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic [7:0] {
    PH_MARK  = 8'b0000_0001,
    PH_RLEN  = 8'b0000_0010,
    PH_TAG   = 8'b0000_0100,
    PH_COL   = 8'b0000_1000,
    PH_INT   = 8'b0001_0000,
    PH_FLT   = 8'b0010_0000,
    PH_SLEN  = 8'b0100_0000,
    PH_SBYTE = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    ETYPE_INT  = 2'd0,
    ETYPE_FLT  = 2'd1,
    ETYPE_STR  = 2'd2,
    ETYPE_NONE = 2'd3
  } etype_t;

  typedef enum logic [2:0] {
    KIND_INT      = 3'd0,
    KIND_FLOAT    = 3'd1,
    KIND_STR_HEAD = 3'd2,
    KIND_STR_BYTE = 3'd3,
    KIND_UNTYPED  = 3'd4,
    KIND_ROW_END  = 3'd5,
    KIND_DONE     = 3'd6,
    KIND_ERROR    = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ROW_BITS-1:0]    row;
    logic [COLUMN_BITS-1:0] column;
    logic [ACC_BITS-1:0]    value;
    logic                   stream_end;
  } result_t;

  // slot 0: decoded value, slot 1: row end, slot 2: done or error
  typedef struct packed {
    logic    [2:0] valid;
    result_t [2:0] slot;
  } bundle_t;

endpackage
`default_nettype wire

// ----- src/tvrp_front.sv -----
// byte parser: accepts one byte per cycle while accept is high and builds the results it causes
`default_nettype none
module tvrp_front
  import tvrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output bundle_t         bundle
);

  phase_t                 phase, phase_next;
  logic [ACC_BITS-1:0]    acc, acc_next;
  logic [3:0]             vbytes, vbytes_next;
  logic [LENGTH_BITS-1:0] row_left, row_left_next;
  logic [LENGTH_BITS-1:0] str_left, str_left_next;
  etype_t                 etype, etype_next;
  logic [COLUMN_BITS-1:0] cur_col, cur_col_next;
  logic [COLUMN_BITS-1:0] prev_col, prev_col_next;
  logic [ROW_BITS-1:0]    row_cnt, row_cnt_next;
  logic [COLUMN_BITS-1:0] widest, widest_next;
  logic                   failed, failed_next;

  logic [6:0]             grp;
  logic                   more;
  logic [6:0]             sh_base;
  logic [6:0]             sh_sel;
  logic [WIDE_BITS-1:0]   wide;
  logic                   len_ovf;
  logic                   col_ovf;

  // group placement shared by all varint phases
  assign grp     = data_byte[6:0];
  assign more    = data_byte[7];
  assign sh_base = {vbytes, 3'b000} - {3'b000, vbytes};
  assign sh_sel  = (phase == PH_COL) ? (sh_base - 7'd3) : sh_base;
  assign wide    = {{ACC_BITS{1'b0}}, grp} << sh_sel;
  assign len_ovf = |wide[WIDE_BITS-1:LENGTH_BITS];
  assign col_ovf = |wide[WIDE_BITS-1:COLUMN_BITS];

  // next state and results for the byte on the input
  always_comb begin
    logic                   err;
    logic                   done;
    logic                   col_done;
    logic                   rend;
    logic                   clear;
    logic [LENGTH_BITS-1:0] rl_dec;

    err      = 1'b0;
    done     = 1'b0;
    col_done = 1'b0;
    rend     = 1'b0;
    clear    = 1'b0;
    rl_dec   = row_left - 1'b1;

    phase_next    = phase;
    acc_next      = acc;
    vbytes_next   = vbytes;
    row_left_next = row_left;
    str_left_next = str_left;
    etype_next    = etype;
    cur_col_next  = cur_col;
    prev_col_next = prev_col;
    row_cnt_next  = row_cnt;
    widest_next   = widest;
    failed_next   = failed;
    bundle        = '0;

    if (failed) begin
      clear = final_byte;
    end else begin
      case (phase)
        PH_MARK: begin
          if (data_byte != ROW_MARKER) begin
            err = 1'b1;
          end else begin
            phase_next  = PH_RLEN;
            acc_next    = '0;
            vbytes_next = '0;
          end
        end
        PH_RLEN: begin
          if (len_ovf) begin
            err = 1'b1;
          end else begin
            vbytes_next = vbytes + 4'd1;
            acc_next    = acc | wide[ACC_BITS-1:0];
            if (more) begin
              err = (vbytes_next >= VARINT_MAX_BYTES);
            end else begin
              row_left_next = acc_next[LENGTH_BITS-1:0];
              if (acc_next[LENGTH_BITS-1:0] == '0) begin
                rend = 1'b1;
              end else begin
                phase_next = PH_TAG;
              end
            end
          end
        end
        default: begin
          row_left_next = rl_dec;
          case (phase)
            PH_TAG: begin
              if (data_byte[2:0] == TAG_TYPE_INT) begin
                etype_next = ETYPE_INT;
              end else if (data_byte[2:0] == TAG_TYPE_FLOAT) begin
                etype_next = ETYPE_FLT;
              end else if (data_byte[2:0] == TAG_TYPE_STRING) begin
                etype_next = ETYPE_STR;
              end else begin
                etype_next = ETYPE_NONE;
              end
              acc_next    = {{(ACC_BITS-4){1'b0}}, data_byte[6:3]};
              vbytes_next = 4'd1;
              if (more) begin
                phase_next = PH_COL;
              end else begin
                col_done = 1'b1;
              end
            end
            PH_COL: begin
              if (col_ovf) begin
                err = 1'b1;
              end else begin
                vbytes_next = vbytes + 4'd1;
                acc_next    = acc | wide[ACC_BITS-1:0];
                if (!more) begin
                  col_done = 1'b1;
                end else begin
                  err = (vbytes_next >= VARINT_MAX_BYTES);
                end
              end
            end
            PH_INT: begin
              // the tenth group keeps only its lowest bit
              acc_next    = acc | wide[ACC_BITS-1:0];
              vbytes_next = vbytes + 4'd1;
              if (!more) begin
                bundle.valid[0] = 1'b1;
                bundle.slot[0]  = '{KIND_INT, row_cnt, cur_col, acc_next, 1'b0};
                done            = 1'b1;
              end else begin
                err = (vbytes_next >= VARINT_MAX_BYTES);
              end
            end
            PH_FLT: begin
              acc_next    = acc | ({{(ACC_BITS-8){1'b0}}, data_byte} << {vbytes[1:0], 3'b000});
              vbytes_next = vbytes + 4'd1;
              if (vbytes_next >= FLOAT_BYTES) begin
                bundle.valid[0] = 1'b1;
                bundle.slot[0]  = '{KIND_FLOAT, row_cnt, cur_col, acc_next, 1'b0};
                done            = 1'b1;
              end
            end
            PH_SLEN: begin
              if (len_ovf) begin
                err = 1'b1;
              end else begin
                vbytes_next = vbytes + 4'd1;
                acc_next    = acc | wide[ACC_BITS-1:0];
                if (!more) begin
                  str_left_next   = acc_next[LENGTH_BITS-1:0];
                  bundle.valid[0] = 1'b1;
                  bundle.slot[0]  = '{KIND_STR_HEAD, row_cnt, cur_col, acc_next, 1'b0};
                  if (acc_next[LENGTH_BITS-1:0] == '0) begin
                    done = 1'b1;
                  end else begin
                    phase_next = PH_SBYTE;
                  end
                end else begin
                  err = (vbytes_next >= VARINT_MAX_BYTES);
                end
              end
            end
            default: begin
              bundle.valid[0] = 1'b1;
              bundle.slot[0]  = '{KIND_STR_BYTE, row_cnt, cur_col,
                                  {{(ACC_BITS-8){1'b0}}, data_byte}, 1'b0};
              str_left_next   = str_left - 1'b1;
              done            = (str_left_next == '0);
            end
          endcase

          // column complete: check order and pick the value phase
          if (col_done) begin
            cur_col_next = acc_next[COLUMN_BITS-1:0];
            if (cur_col_next <= prev_col) begin
              err = 1'b1;
            end else begin
              prev_col_next = cur_col_next;
              acc_next      = '0;
              vbytes_next   = '0;
              case (etype_next)
                ETYPE_INT: phase_next = PH_INT;
                ETYPE_FLT: phase_next = PH_FLT;
                ETYPE_STR: phase_next = PH_SLEN;
                default: begin
                  bundle.valid[0] = 1'b1;
                  bundle.slot[0]  = '{KIND_UNTYPED, row_cnt, cur_col_next, '0, 1'b0};
                  done            = 1'b1;
                end
              endcase
            end
          end

          // entry finished or row bytes exhausted
          if (!err) begin
            if (done) begin
              phase_next = PH_TAG;
              rend       = (rl_dec == '0);
            end else if (rl_dec == '0) begin
              err = 1'b1;
            end
          end
        end
      endcase

      // row end
      if (rend) begin
        bundle.valid[1] = 1'b1;
        bundle.slot[1]  = '{KIND_ROW_END, row_cnt, prev_col_next, '0, 1'b0};
        if (prev_col_next > widest) begin
          widest_next = prev_col_next;
        end
        row_cnt_next  = row_cnt + 1'b1;
        prev_col_next = '0;
        cur_col_next  = '0;
        phase_next    = PH_MARK;
      end

      // closing result of the stream
      if (err) begin
        bundle.valid[2] = 1'b1;
        bundle.slot[2]  = '{KIND_ERROR, row_cnt_next, cur_col_next, '0, 1'b1};
        failed_next     = 1'b1;
        clear           = final_byte;
      end else if (final_byte) begin
        bundle.valid[2] = 1'b1;
        if (phase_next == PH_MARK) begin
          bundle.slot[2] = '{KIND_DONE, row_cnt_next, widest_next, '0, 1'b1};
        end else begin
          bundle.slot[2] = '{KIND_ERROR, row_cnt_next, cur_col_next, '0, 1'b1};
        end
        clear = 1'b1;
      end
    end

    // back to the starting state
    if (clear) begin
      phase_next    = PH_MARK;
      acc_next      = '0;
      vbytes_next   = '0;
      row_left_next = '0;
      str_left_next = '0;
      etype_next    = ETYPE_INT;
      cur_col_next  = '0;
      prev_col_next = '0;
      row_cnt_next  = '0;
      widest_next   = '0;
      failed_next   = 1'b0;
    end
  end

  // parse state, advanced on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MARK;
      acc      <= '0;
      vbytes   <= '0;
      row_left <= '0;
      str_left <= '0;
      etype    <= ETYPE_INT;
      cur_col  <= '0;
      prev_col <= '0;
      row_cnt  <= '0;
      widest   <= '0;
      failed   <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      acc      <= acc_next;
      vbytes   <= vbytes_next;
      row_left <= row_left_next;
      str_left <= str_left_next;
      etype    <= etype_next;
      cur_col  <= cur_col_next;
      prev_col <= prev_col_next;
      row_cnt  <= row_cnt_next;
      widest   <= widest_next;
      failed   <= failed_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/tvrp_queue.sv -----
// short queue of result bundles between the parser and the result side
`default_nettype none
module tvrp_queue
  import tvrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  bundle_t   wr_data,
  input  wire logic rd,
  output bundle_t   rd_data,
  output logic      full,
  output logic      empty
);

  bundle_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;
  logic                      do_wr;
  logic                      do_rd;

  assign full    = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/tvrp_back.sv -----
// result side: unpacks bundles and presents one result at a time
`default_nettype none
module tvrp_back
  import tvrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  bundle_t   q_data,
  input  wire logic q_empty,
  output logic      q_rd,
  input  wire logic pop,
  output logic      empty,
  output result_t   res
);

  bundle_t    hold;
  logic [2:0] left;
  logic [2:0] left_after;
  logic       take;
  logic       load;

  assign empty = (left == '0);
  assign take  = pop && !empty;

  // oldest remaining slot and what is left once it is taken
  always_comb begin
    if (left[0]) begin
      res        = hold.slot[0];
      left_after = {left[2:1], 1'b0};
    end else if (left[1]) begin
      res        = hold.slot[1];
      left_after = {left[2], 2'b00};
    end else begin
      res        = hold.slot[2];
      left_after = 3'b000;
    end
  end

  assign load = empty || (take && (left_after == '0));
  assign q_rd = load && !q_empty;

  // held bundle
  always_ff @(posedge clk) begin
    if (q_rd) begin
      hold <= q_data;
    end
  end

  // remaining slot mask
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (q_rd) begin
      left <= q_data.valid;
    end else if (take) begin
      left <= left_after;
    end
  end

endmodule
`default_nettype wire

// ----- src/tagged_varint_record_parser.sv -----
// top level of the tagged varint record parser
//
// Parses a table stream one byte per transfer: rows open with a 0x0a marker and a
// varint length, entries carry a tag byte with type and column, then an integer
// varint, four float bytes or a string length and its bytes. A byte is taken in
// the cycle it is pushed while full is low, so bytes stream in at one per cycle;
// each byte yields zero to three results (a decoded value, a row end, a final done
// or error), and the result side hands out one result per cycle while pop is high.
// A four-entry queue of per-byte result groups sits between the parser and the
// result side, so full rises once four groups wait; the sustained byte rate is one
// per cycle while bytes average at most one result, and otherwise is set by the
// one-result-per-cycle output. Results pass a queue entry, then the held bundle.
`default_nettype none
module tagged_varint_record_parser
  import tvrp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   final_byte,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [2:0]                  kind,
  output logic [ROW_BITS-1:0]         row,
  output logic [COLUMN_BITS-1:0]      column,
  output logic signed [ACC_BITS-1:0]  value,
  output logic                        stream_end
);

  bundle_t front_bundle;
  bundle_t q_data;
  logic    accept;
  logic    q_empty;
  logic    q_rd;
  result_t res;

  assign accept = push && !full;

  // parser
  tvrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .bundle     (front_bundle)
  );

  // result group queue
  tvrp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && (front_bundle.valid != '0)),
    .wr_data (front_bundle),
    .rd      (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  // result side
  tvrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign kind       = res.kind;
  assign row        = res.row;
  assign column     = res.column;
  assign value      = res.value;
  assign stream_end = res.stream_end;

endmodule
`default_nettype wire

// ----- verif/tvrp_tb_pkg.sv -----
// result tracker class for the tagged varint record parser testbench
package tvrp_tb_pkg;
  import tvrp_pkg::*;

  class table_result_tracker;
    // mirrored parse state
    phase_t                 ph;
    logic [63:0]            acc;
    int unsigned            vcount;
    logic [LENGTH_BITS-1:0] row_left;
    logic [LENGTH_BITS-1:0] str_left;
    etype_t                 ety;
    logic [COLUMN_BITS-1:0] col_now;
    logic [COLUMN_BITS-1:0] col_prev;
    logic [COLUMN_BITS-1:0] col_max;
    logic [ROW_BITS-1:0]    row_num;
    bit                     halted;

    result_t     expected_results[$];
    int unsigned seen_total;
    int unsigned seen_row_end;
    int unsigned seen_done;
    int unsigned seen_error;

    function void restart();
      ph       = PH_MARK;
      acc      = '0;
      vcount   = 0;
      row_left = '0;
      str_left = '0;
      ety      = ETYPE_INT;
      col_now  = '0;
      col_prev = '0;
      col_max  = '0;
      row_num  = '0;
      halted   = 1'b0;
    endfunction

    function void queue_result(kind_t k, logic [COLUMN_BITS-1:0] col, logic [63:0] val,
                               logic fin);
      result_t r;
      r.kind       = k;
      r.row        = row_num;
      r.column     = col;
      r.value      = val;
      r.stream_end = fin;
      expected_results.insert(expected_results.size(), r);
    endfunction

    // merge a 7-bit group at an offset, refusing bits at or above the limit
    function bit merge_group(logic [63:0] g, int unsigned shift, int unsigned bits);
      if (shift >= bits) return g == 64'd0;
      if ((g >> (bits - shift)) != 64'd0) return 1'b0;
      acc |= g << shift;
      return 1'b1;
    endfunction

    function void close_row();
      queue_result(KIND_ROW_END, col_prev, 64'd0, 1'b0);
      if (col_prev > col_max) col_max = col_prev;
      row_num  = row_num + 1'b1;
      col_prev = '0;
      col_now  = '0;
      ph       = PH_MARK;
    endfunction

    // work out the results that one accepted byte causes
    function void decode_byte(logic [7:0] b, logic fin);
      logic [63:0] g;
      logic        more;
      logic        err;
      logic        done;
      logic        col_done;
      logic [2:0]  t;
      g        = {57'd0, b[6:0]};
      more     = b[7];
      err      = 1'b0;
      done     = 1'b0;
      col_done = 1'b0;
      if (halted) begin
        if (fin) restart();
        return;
      end
      case (ph)
        PH_MARK: begin
          if (b != ROW_MARKER) begin
            err = 1'b1;
          end else begin
            ph     = PH_RLEN;
            acc    = '0;
            vcount = 0;
          end
        end
        PH_RLEN: begin
          if (!merge_group(g, 7 * vcount, LENGTH_BITS)) begin
            err = 1'b1;
          end else begin
            vcount++;
            if (more) begin
              if (vcount >= VARINT_MAX_BYTES) err = 1'b1;
            end else begin
              row_left = acc[LENGTH_BITS-1:0];
              if (row_left == 0) close_row();
              else ph = PH_TAG;
            end
          end
        end
        default: begin
          row_left = row_left - 1'b1;
          case (ph)
            PH_TAG: begin
              t = b[2:0];
              ety = (t == TAG_TYPE_INT) ? ETYPE_INT : (t == TAG_TYPE_FLOAT) ? ETYPE_FLT
                  : (t == TAG_TYPE_STRING) ? ETYPE_STR : ETYPE_NONE;
              acc    = {60'd0, b[6:3]};
              vcount = 1;
              if (more) ph = PH_COL;
              else col_done = 1'b1;
            end
            PH_COL: begin
              if (!merge_group(g, 7 * vcount - 3, COLUMN_BITS)) begin
                err = 1'b1;
              end else begin
                vcount++;
                if (!more) col_done = 1'b1;
                else if (vcount >= VARINT_MAX_BYTES) err = 1'b1;
              end
            end
            PH_INT: begin
              acc |= g << (7 * vcount);
              vcount++;
              if (!more) begin
                queue_result(KIND_INT, col_now, acc, 1'b0);
                done = 1'b1;
              end else if (vcount >= VARINT_MAX_BYTES) begin
                err = 1'b1;
              end
            end
            PH_FLT: begin
              acc |= {56'd0, b} << (8 * (vcount % 4));
              vcount++;
              if (vcount >= FLOAT_BYTES) begin
                queue_result(KIND_FLOAT, col_now, acc, 1'b0);
                done = 1'b1;
              end
            end
            PH_SLEN: begin
              if (!merge_group(g, 7 * vcount, LENGTH_BITS)) begin
                err = 1'b1;
              end else begin
                vcount++;
                if (!more) begin
                  str_left = acc[LENGTH_BITS-1:0];
                  queue_result(KIND_STR_HEAD, col_now, acc, 1'b0);
                  if (str_left == 0) done = 1'b1;
                  else ph = PH_SBYTE;
                end else if (vcount >= VARINT_MAX_BYTES) begin
                  err = 1'b1;
                end
              end
            end
            default: begin
              queue_result(KIND_STR_BYTE, col_now, {56'd0, b}, 1'b0);
              str_left = str_left - 1'b1;
              if (str_left == 0) done = 1'b1;
            end
          endcase

          // column complete: check it rises, then pick the value phase
          if (col_done) begin
            col_now = acc[COLUMN_BITS-1:0];
            if (col_now <= col_prev) begin
              err = 1'b1;
            end else begin
              col_prev = col_now;
              acc      = '0;
              vcount   = 0;
              case (ety)
                ETYPE_INT: ph = PH_INT;
                ETYPE_FLT: ph = PH_FLT;
                ETYPE_STR: ph = PH_SLEN;
                default: begin
                  queue_result(KIND_UNTYPED, col_now, 64'd0, 1'b0);
                  done = 1'b1;
                end
              endcase
            end
          end

          // row budget: entry must finish on or before the last row byte
          if (!err) begin
            if (done) begin
              ph = PH_TAG;
              if (row_left == 0) close_row();
            end else if (row_left == 0) begin
              err = 1'b1;
            end
          end
        end
      endcase

      if (err) begin
        queue_result(KIND_ERROR, col_now, 64'd0, 1'b1);
        if (fin) restart();
        else halted = 1'b1;
        return;
      end
      if (fin) begin
        if (ph == PH_MARK) queue_result(KIND_DONE, col_max, 64'd0, 1'b1);
        else queue_result(KIND_ERROR, col_now, 64'd0, 1'b1);
        restart();
      end
    endfunction

    // compare one popped result with the oldest expected one
    function bit compare_result(result_t got, output string why);
      result_t want;
      if (expected_results.size() == 0) begin
        why = $sformatf("result with nothing expected: kind %0d row %0d column %0d",
                        got.kind, got.row, got.column);
        return 1'b0;
      end
      want = expected_results.pop_front();
      seen_total++;
      case (want.kind)
        KIND_ROW_END: seen_row_end++;
        KIND_DONE:    seen_done++;
        KIND_ERROR:   seen_error++;
        default: ;
      endcase
      why = "";
      if (got.kind !== want.kind)
        why = {why, $sformatf(" kind %0d want %0d", got.kind, want.kind)};
      if (got.row !== want.row)
        why = {why, $sformatf(" row %0d want %0d", got.row, want.row)};
      if (got.column !== want.column)
        why = {why, $sformatf(" column %0d want %0d", got.column, want.column)};
      if (got.value !== want.value)
        why = {why, $sformatf(" value %h want %h", got.value, want.value)};
      if (got.stream_end !== want.stream_end)
        why = {why, $sformatf(" stream_end %0d want %0d", got.stream_end, want.stream_end)};
      if (why != "") begin
        why = {$sformatf("result %0d (kind %0d):", seen_total, want.kind), why};
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

endpackage

// ----- verif/testbench.sv -----
// top-level testbench for the tagged varint record parser
module testbench;
  import tvrp_pkg::*;
  import tvrp_tb_pkg::*;

  localparam int BYTES_PER_PHASE = 40;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 20;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic [7:0]                    data_byte;
  logic                          final_byte;
  logic                          empty;
  logic                          pop;
  logic [2:0]                    kind;
  logic [ROW_BITS-1:0]           row;
  logic [COLUMN_BITS-1:0]        column;
  logic signed [ACC_BITS-1:0]    value;
  logic                          stream_end;

  table_result_tracker tracker;

  logic [8:0]  feed_q[$];   // {final, byte} waiting to go out
  logic [7:0]  body_q[$];   // entry bytes of the row being built
  logic [7:0]  vb_q[$];     // bytes of the last encoded varint
  int unsigned last_col;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  bit          rx_hold;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned streams_built;

  tagged_varint_record_parser DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .row        (row),
    .column     (column),
    .value      (value),
    .stream_end (stream_end)
  );

  always #6 clk = ~clk;

  task automatic report(string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  // stream building
  function automatic void put_byte(logic [7:0] b, bit f);
    feed_q.insert(feed_q.size(), {f, b});
  endfunction

  function automatic void emit_varint(logic [63:0] v);
    logic [7:0] b;
    vb_q.delete();
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      vb_q.insert(vb_q.size(), b);
    end while (v != 0);
  endfunction

  // varint of a given byte count with random groups
  function automatic void emit_raw(int unsigned n);
    vb_q.delete();
    repeat (n - 1) vb_q.insert(vb_q.size(), {1'b1, 7'($urandom)});
    vb_q.insert(vb_q.size(), {1'b0, 7'($urandom)});
  endfunction

  function automatic void append_body();
    foreach (vb_q[i]) body_q.insert(body_q.size(), vb_q[i]);
  endfunction

  // one entry; wild entries may break columns, varints and lengths
  function automatic bit add_entry(bit wild);
    int unsigned col;
    int unsigned pick;
    int unsigned len;
    int unsigned w;
    logic [2:0]  ty;
    logic [63:0] v;
    col = last_col + $urandom_range(1, 3);
    if ($urandom_range(7) == 0) col = last_col + $urandom_range(1, 20000);
    if (wild && $urandom_range(5) == 0)
      col = $urandom_range(1) ? last_col : 32'h10000 + $urandom_range(0, 32'hfffff);
    if (!wild && col > 65535) return 1'b0;
    last_col = col;
    pick = $urandom_range(3);
    case (pick)
      0: ty = TAG_TYPE_INT;
      1: ty = TAG_TYPE_FLOAT;
      2: ty = TAG_TYPE_STRING;
      default: begin
        do ty = 3'($urandom);
        while (ty == TAG_TYPE_INT || ty == TAG_TYPE_FLOAT || ty == TAG_TYPE_STRING);
      end
    endcase
    body_q.insert(body_q.size(), {(col >> 4) != 0, col[3:0], ty});
    if ((col >> 4) != 0) begin
      emit_varint(64'(col >> 4));
      append_body();
    end
    case (pick)
      0: begin
        if (wild && $urandom_range(3) == 0) begin
          emit_raw($urandom_range(9, 11));
        end else if ($urandom_range(5) == 0) begin
          emit_raw($urandom_range(1, 10));
        end else begin
          w = $urandom_range(64);
          v = {$urandom, $urandom};
          if (w < 64) v = v & ((64'd1 << w) - 64'd1);
          emit_varint(v);
        end
        append_body();
      end
      1: repeat (4) body_q.insert(body_q.size(), 8'($urandom));
      2: begin
        len = $urandom_range(4);
        if (wild && $urandom_range(4) == 0) emit_varint((64'd1 << LENGTH_BITS) | len);
        else emit_varint(64'(len));
        append_body();
        repeat (len) body_q.insert(body_q.size(), 8'($urandom));
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic void add_row(bit wild);
    int unsigned n;
    int unsigned len;
    body_q.delete();
    last_col = 0;
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      if (!add_entry(wild)) break;
    end
    len = body_q.size();
    if (wild) begin
      case ($urandom_range(3))
        0: if (len > 0) len--;
        1: len++;
        2: len = len | (1 << LENGTH_BITS);
        default: ;
      endcase
    end
    put_byte(ROW_MARKER, 1'b0);
    emit_varint(64'(len));
    foreach (vb_q[i]) put_byte(vb_q[i], 1'b0);
    foreach (body_q[i]) put_byte(body_q[i], 1'b0);
  endfunction

  // mostly well-formed streams, some broken ones, a little noise
  function automatic void add_stream();
    int unsigned start;
    int unsigned sel;
    int unsigned n;
    int unsigned idx;
    start = feed_q.size();
    sel = $urandom_range(9);
    if (sel < 7) begin
      repeat ($urandom_range(1, 3)) add_row(1'b0);
    end else if (sel < 9) begin
      repeat ($urandom_range(1, 3)) add_row($urandom_range(1));
      n = feed_q.size() - start;
      if ($urandom_range(2) == 0 && n > 1) begin
        idx = start + $urandom_range(0, n - 1);
        feed_q[idx] = {1'b0, 8'($urandom)};
      end
      if ($urandom_range(1) == 0 && n > 1)
        repeat ($urandom_range(1, n - 1)) void'(feed_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 6))
        put_byte(($urandom_range(2) == 0) ? ROW_MARKER : 8'($urandom), 1'b0);
    end
    feed_q[feed_q.size() - 1][8] = 1'b1;
    streams_built++;
  endfunction

  // directed streams: empty row, bad marker, float then truncation,
  // untyped then a column that does not rise, extended column with empty
  // string, row length too wide
  function automatic void load_directed();
    put_byte(8'h0a, 1'b0); put_byte(8'h00, 1'b1);
    put_byte(8'h55, 1'b1);
    put_byte(8'h0a, 1'b0); put_byte(8'h05, 1'b0); put_byte(8'h0d, 1'b0);
    put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h80, 1'b0);
    put_byte(8'hff, 1'b0); put_byte(8'h0a, 1'b1);
    put_byte(8'h0a, 1'b0); put_byte(8'h02, 1'b0); put_byte(8'h0b, 1'b0);
    put_byte(8'h0b, 1'b1);
    put_byte(8'h0a, 1'b0); put_byte(8'h03, 1'b0); put_byte(8'h92, 1'b0);
    put_byte(8'h01, 1'b0); put_byte(8'h00, 1'b1);
    put_byte(8'h0a, 1'b0); put_byte(8'h80, 1'b0); put_byte(8'h80, 1'b0);
    put_byte(8'h80, 1'b0); put_byte(8'h08, 1'b1);
    streams_built += 6;
  endfunction

  // push every queued byte, idling at random between transfers
  task automatic send_feed();
    logic [8:0] item;
    while (feed_q.size() > 0) begin
      item = feed_q.pop_front();
      while ($urandom_range(99) < tx_idle_pct) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push       <= 1'b1;
      data_byte  <= item[7:0];
      final_byte <= item[8];
      do @(posedge clk); while (full);
      tracker.decode_byte(item[7:0], item[8]);
      bytes_sent++;
    end
  endtask

  task automatic check_output();
    result_t got;
    string   why;
    got.kind       = kind_t'(kind);
    got.row        = row;
    got.column     = column;
    got.value      = value;
    got.stream_end = stream_end;
    if (!tracker.compare_result(got, why)) report(why);
  endtask

  // result side: pop at random, hold off when asked
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_output();
      pop <= !rst && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // run limit
  initial begin
    #(12 * 200000);
    $display("tagged_varint_record_parser test failed");
    $finish;
  end

  initial begin
    tracker      = new();
    push        <= 1'b0;
    data_byte   <= 8'h00;
    final_byte  <= 1'b0;
    rst         <= 1'b1;
    rx_hold     <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    mismatches   = 0;
    bytes_sent   = 0;
    streams_built = 0;
    tracker.restart();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_directed();
    send_feed();

    // pacing phases: none, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      // long receiver hold-off so the block backs up into full
      if (p == 0) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      while (feed_q.size() < BYTES_PER_PHASE) add_stream();
      send_feed();
    end
    push <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d streams across four pacing phases",
             bytes_sent, streams_built);
    $display("checked %0d results: %0d row ends, %0d done, %0d errors, %0d mismatches",
             tracker.seen_total, tracker.seen_row_end, tracker.seen_done,
             tracker.seen_error, mismatches);
    if (mismatches == 0) begin
      $display("tagged_varint_record_parser test passed");
    end else begin
      $display("tagged_varint_record_parser test failed");
    end
    $finish;
  end

endmodule
